// ----- design/local_affine_alignment_fill_defines.svh -----
// Assertion macros for the affine-gap local alignment fill block.
// Included by files that carry concurrent checks; relies on ports clock and reset.
`ifndef LOCAL_AFFINE_ALIGNMENT_FILL_DEFINES_SVH
`define LOCAL_AFFINE_ALIGNMENT_FILL_DEFINES_SVH

// same-cycle implication, off during reset
`define LAFA_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define LAFA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/lafa_pkg.sv -----
// Shared types and constants for the affine-gap local alignment fill block.
// No dependencies; imported by every module of the block.
package lafa_pkg;

   localparam int MAX_COLS_DEFAULT   = 1024;
   localparam int MAX_ROWS_DEFAULT   = 1024;
   localparam int SCORE_BITS_DEFAULT = 16;

   localparam int CSR_W       = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int MATCH_W     = 11;
   localparam int CELL_W      = 15;
   localparam int POS_OUT_W   = 11;

   localparam logic signed [CSR_W-1:0] ROW_GAP_OPEN_RST   = -11'sd10;
   localparam logic signed [CSR_W-1:0] ROW_GAP_EXTEND_RST = -11'sd1;
   localparam logic signed [CSR_W-1:0] COL_GAP_OPEN_RST   = -11'sd10;
   localparam logic signed [CSR_W-1:0] COL_GAP_EXTEND_RST = -11'sd1;
   localparam logic [CSR_W-1:0]        COL_COUNT_RST      = 11'd1024;
   localparam logic [CSR_W-1:0]        ROW_COUNT_RST      = 11'd1024;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_GAP_OPEN   = 3'd0,
      CSR_ROW_GAP_EXTEND = 3'd1,
      CSR_COL_GAP_OPEN   = 3'd2,
      CSR_COL_GAP_EXTEND = 3'd3,
      CSR_COL_COUNT      = 3'd4,
      CSR_ROW_COUNT      = 3'd5
   } lafa_csr_index_type;

   typedef enum logic [1:0] {
      TRACE_STOP  = 2'd0,
      TRACE_INS   = 2'd1,
      TRACE_DEL   = 2'd2,
      TRACE_MATCH = 2'd3
   } lafa_trace_type;

   // position flags of one cell, taken at request time
   typedef struct packed {
      logic first_row;
      logic first_col;
      logic at_count;
      logic last;
   } lafa_flags_type;

endpackage

// ----- design/lafa_seq.sv -----
// Cell position sequencer: row/column counters and effective matrix size.
// Depends on lafa_pkg.
module lafa_seq import lafa_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   localparam int CPW = $clog2(MAX_COLS + 1),
   localparam int RPW = $clog2(MAX_ROWS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [CSR_W-1:0] col_count,
   input  logic [CSR_W-1:0] row_count,
   output logic [CPW-1:0]   col_pos,
   output logic [RPW-1:0]   row_pos,
   output logic [CPW-1:0]   eff_cols,
   output lafa_flags_type   flags
);

   logic [CPW-1:0] col_pos_ff, col_pos_in;
   logic [RPW-1:0] row_pos_ff, row_pos_in;
   logic [RPW-1:0] eff_rows;
   logic           row_end, mat_end;

   // zero acts as one, oversize clamps to the maximum
   always_comb begin
      if (col_count == '0) begin
         eff_cols = CPW'(1);
      end else if (32'(col_count) > MAX_COLS) begin
         eff_cols = CPW'(MAX_COLS);
      end else begin
         eff_cols = CPW'(col_count);
      end
      if (row_count == '0) begin
         eff_rows = RPW'(1);
      end else if (32'(row_count) > MAX_ROWS) begin
         eff_rows = RPW'(MAX_ROWS);
      end else begin
         eff_rows = RPW'(row_count);
      end
   end

   assign row_end = (col_pos_ff >= eff_cols);
   assign mat_end = row_end && (row_pos_ff >= eff_rows);

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (advance) begin
         if (mat_end) begin
            col_pos_in = CPW'(1);
            row_pos_in = RPW'(1);
         end else if (row_end) begin
            col_pos_in = CPW'(1);
            row_pos_in = row_pos_ff + RPW'(1);
         end else begin
            col_pos_in = col_pos_ff + CPW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= CPW'(1);
         row_pos_ff <= RPW'(1);
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

   assign col_pos         = col_pos_ff;
   assign row_pos         = row_pos_ff;
   assign flags.first_row = (row_pos_ff <= RPW'(1));
   assign flags.first_col = (col_pos_ff == CPW'(1));
   assign flags.at_count  = (col_pos_ff == eff_cols);
   assign flags.last      = mat_end;

endmodule

// ----- design/lafa_store.sv -----
// Row stores: previous-row score and vertical gap, one entry per column.
// Registered reads, same-entry bypass and a fill count. Depends on lafa_pkg.
module lafa_store import lafa_pkg::*; #(
   parameter int MAX_COLS   = MAX_COLS_DEFAULT,
   parameter int SCORE_BITS = SCORE_BITS_DEFAULT,
   localparam int CPW = $clog2(MAX_COLS + 1),
   localparam int VW  = (SCORE_BITS > CSR_W) ? SCORE_BITS : CSR_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [CPW-1:0]               rd_addr,
   input  logic                         wr_en,
   input  logic [CPW-1:0]               wr_addr,
   input  logic signed [SCORE_BITS-1:0] wr_score,
   input  logic signed [SCORE_BITS-1:0] wr_gap,
   input  logic                         restart,
   input  logic [CPW-1:0]               eff_cols,
   input  logic signed [CSR_W-1:0]      col_gap_open,
   input  logic signed [CSR_W-1:0]      row_gap_open,
   output logic signed [VW-1:0]         up_score,
   output logic signed [VW-1:0]         up_gap
);

   localparam logic [CPW-1:0] INIT_COLS_RST =
      (32'(COL_COUNT_RST) > MAX_COLS) ? CPW'(MAX_COLS) : CPW'(COL_COUNT_RST);

   logic signed [SCORE_BITS-1:0] score_mem [0:MAX_COLS];
   logic signed [SCORE_BITS-1:0] gap_mem   [0:MAX_COLS];

   logic signed [SCORE_BITS-1:0] mem_score_ff, mem_gap_ff;
   logic signed [SCORE_BITS-1:0] fwd_score_ff, fwd_gap_ff;
   logic signed [CSR_W-1:0]      sub_score_ff, sub_gap_ff;
   logic                         fwd_ff, hit_ff;

   logic [CPW-1:0]          fill_ff, fill_in;
   logic [CPW-1:0]          init_cols_ff, init_cols_in;
   logic signed [CSR_W-1:0] init_cgo_ff, init_cgo_in;
   logic signed [CSR_W-1:0] init_rgo_ff, init_rgo_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         score_mem[wr_addr] <= wr_score;
         gap_mem[wr_addr]   <= wr_gap;
      end
   end

   // Entries past the fill count were not written this matrix and read as
   // their start values. A write landing in the read cycle is bypassed.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_score_ff <= score_mem[rd_addr];
         mem_gap_ff   <= gap_mem[rd_addr];
         fwd_ff       <= wr_en && (wr_addr == rd_addr);
         fwd_score_ff <= wr_score;
         fwd_gap_ff   <= wr_gap;
         hit_ff       <= (rd_addr <= fill_ff);
         sub_score_ff <= (rd_addr == init_cols_ff) ? init_cgo_ff : '0;
         sub_gap_ff   <= init_rgo_ff;
      end
   end

   // each row writes columns 1..k in order, so the written set is 1..max k
   always_comb begin
      fill_in      = fill_ff;
      init_cols_in = init_cols_ff;
      init_cgo_in  = init_cgo_ff;
      init_rgo_in  = init_rgo_ff;
      if (restart) begin
         fill_in      = '0;
         init_cols_in = eff_cols;
         init_cgo_in  = col_gap_open;
         init_rgo_in  = row_gap_open;
      end else if (wr_en && (wr_addr > fill_ff)) begin
         fill_in = wr_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         init_cols_ff <= INIT_COLS_RST;
         init_cgo_ff  <= COL_GAP_OPEN_RST;
         init_rgo_ff  <= ROW_GAP_OPEN_RST;
      end else begin
         fill_ff      <= fill_in;
         init_cols_ff <= init_cols_in;
         init_cgo_ff  <= init_cgo_in;
         init_rgo_ff  <= init_rgo_in;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         up_score = VW'(fwd_score_ff);
         up_gap   = VW'(fwd_gap_ff);
      end else if (hit_ff) begin
         up_score = VW'(mem_score_ff);
         up_gap   = VW'(mem_gap_ff);
      end else begin
         up_score = VW'(sub_score_ff);
         up_gap   = VW'(sub_gap_ff);
      end
   end

endmodule

// ----- design/lafa_cell.sv -----
// Cell recurrence: affine gap candidates, clamp, trace, running best and
// the result register. Depends on lafa_pkg.
module lafa_cell import lafa_pkg::*; #(
   parameter int MAX_COLS   = MAX_COLS_DEFAULT,
   parameter int MAX_ROWS   = MAX_ROWS_DEFAULT,
   parameter int SCORE_BITS = SCORE_BITS_DEFAULT,
   localparam int CPW = $clog2(MAX_COLS + 1),
   localparam int RPW = $clog2(MAX_ROWS + 1),
   localparam int VW  = (SCORE_BITS > CSR_W) ? SCORE_BITS : CSR_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  lafa_flags_type               flags,
   input  logic signed [MATCH_W-1:0]    match_score,
   input  logic [CPW-1:0]               col_pos,
   input  logic [RPW-1:0]               row_pos,
   input  logic signed [VW-1:0]         up_mem,
   input  logic signed [VW-1:0]         upgap_mem,
   input  logic signed [CSR_W-1:0]      row_gap_open,
   input  logic signed [CSR_W-1:0]      row_gap_extend,
   input  logic signed [CSR_W-1:0]      col_gap_open,
   input  logic signed [CSR_W-1:0]      col_gap_extend,
   output logic signed [SCORE_BITS-1:0] wr_score,
   output logic signed [SCORE_BITS-1:0] wr_gap,
   output logic [1:0]                   rsp_trace_code,
   output logic [CELL_W-1:0]            rsp_cell_score,
   output logic [CELL_W-1:0]            rsp_best_score,
   output logic [POS_OUT_W-1:0]         rsp_best_row,
   output logic [POS_OUT_W-1:0]         rsp_best_col,
   output logic                         rsp_last_cell
);

   localparam int SUM_W = VW + 2;
   localparam int XW    = (SCORE_BITS > 16) ? SCORE_BITS : 16;

   localparam logic signed [SUM_W-1:0] SAT_HI =
      SUM_W'((64'sd1 <<< (SCORE_BITS - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;
   localparam logic signed [XW-1:0]    CELL_CAP = XW'(32767);

   function automatic logic signed [SCORE_BITS-1:0] sat_score(
      input logic signed [SUM_W-1:0] v
   );
      logic signed [SCORE_BITS-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[SCORE_BITS-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SCORE_BITS-1:0];
      end else begin
         r = v[SCORE_BITS-1:0];
      end
      return r;
   endfunction

   logic signed [VW-1:0]         diag_ff;
   logic signed [SCORE_BITS-1:0] left_ff, along_ff;
   logic [CELL_W-1:0]            best_value_ff;
   logic [RPW-1:0]               best_row_ff;
   logic [CPW-1:0]               best_col_ff;

   logic signed [VW-1:0]         up, upgap, along, diag;
   logic signed [SCORE_BITS-1:0] left;
   logic signed [SCORE_BITS-1:0] e_ext, e_open, e, d_ext, d_open, d, c_diag, c_max, c;
   logic signed [XW-1:0]         c_x;
   logic [CELL_W-1:0]            cell15;
   lafa_trace_type               trace;
   logic                         better;

   always_comb begin
      if (flags.first_row) begin
         up    = flags.at_count ? VW'(col_gap_open) : VW'(0);
         upgap = VW'(row_gap_open);
      end else begin
         up    = up_mem;
         upgap = upgap_mem;
      end
      if (flags.first_col) begin
         left  = '0;
         along = VW'(col_gap_open);
         diag  = '0;
      end else begin
         left  = left_ff;
         along = VW'(along_ff);
         diag  = diag_ff;
      end
   end

   always_comb begin
      e_ext  = sat_score(SUM_W'(along) + SUM_W'(col_gap_extend));
      e_open = sat_score(SUM_W'(left) + SUM_W'(col_gap_open) + SUM_W'(col_gap_extend));
      e      = (e_open > e_ext) ? e_open : e_ext;
      d_ext  = sat_score(SUM_W'(upgap) + SUM_W'(row_gap_extend));
      d_open = sat_score(SUM_W'(up) + SUM_W'(row_gap_open) + SUM_W'(row_gap_extend));
      d      = (d_open > d_ext) ? d_open : d_ext;
      c_diag = sat_score(SUM_W'(diag) + SUM_W'(match_score));
      c_max  = (e > c_diag) ? e : c_diag;
      if (d > c_max) begin
         c_max = d;
      end
      // tie order: insertion, deletion, match
      if (c_max <= 0) begin
         c     = '0;
         trace = TRACE_STOP;
      end else if (c_max == d) begin
         c     = c_max;
         trace = TRACE_INS;
      end else if (c_max == e) begin
         c     = c_max;
         trace = TRACE_DEL;
      end else begin
         c     = c_max;
         trace = TRACE_MATCH;
      end
      c_x    = XW'(c);
      cell15 = (c_x > CELL_CAP) ? CELL_W'(32767) : c_x[CELL_W-1:0];
      better = (cell15 > best_value_ff);
   end

   assign wr_score = c;
   assign wr_gap   = d;

   always_ff @(posedge clock) begin
      if (fire) begin
         diag_ff        <= up;
         left_ff        <= c;
         along_ff       <= e;
         rsp_trace_code <= trace;
         rsp_cell_score <= cell15;
         rsp_best_score <= better ? cell15 : best_value_ff;
         rsp_best_row   <= better ? POS_OUT_W'(row_pos) : POS_OUT_W'(best_row_ff);
         rsp_best_col   <= better ? POS_OUT_W'(col_pos) : POS_OUT_W'(best_col_ff);
         rsp_last_cell  <= flags.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_value_ff <= '0;
         best_row_ff   <= '0;
         best_col_ff   <= '0;
      end else if (fire) begin
         if (flags.last) begin
            best_value_ff <= '0;
            best_row_ff   <= '0;
            best_col_ff   <= '0;
         end else if (better) begin
            best_value_ff <= cell15;
            best_row_ff   <= row_pos;
            best_col_ff   <= col_pos;
         end
      end
   end

endmodule

// ----- design/local_affine_alignment_fill.sv -----
// Top level of the affine-gap local alignment fill: CSRs, handshake, pipeline.
// Depends on lafa_pkg, lafa_seq, lafa_store, lafa_cell and the defines header.
//
//   channel | ports                          | role
//   --------+--------------------------------+-----------------------------
//   req     | req_valid/ready, match_score   | one cell score, row-major
//   rsp     | rsp_valid/ready, trace..last   | one result per request
//   csr     | csr_we, csr_index, csr_wdata   | gap penalties and counts
//
// Sustains one cell per clock while results are taken. A result is registered
// when the compute stage fires after its request is accepted (row-store read
// on the accepting edge, then recurrence into the result register). The
// left-to-right cell dependency closes in lafa_cell through its cell registers.
// Reset is synchronous; the row stores need no clearing pass (fill count).
// A held result stalls the request side only when the compute stage is full.
`include "local_affine_alignment_fill_defines.svh"

module local_affine_alignment_fill import lafa_pkg::*; #(
   parameter int MAX_COLS   = MAX_COLS_DEFAULT,
   parameter int MAX_ROWS   = MAX_ROWS_DEFAULT,
   parameter int SCORE_BITS = SCORE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [MATCH_W-1:0] req_match_score,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_trace_code,
   output logic [CELL_W-1:0]        rsp_cell_score,
   output logic [CELL_W-1:0]        rsp_best_score,
   output logic [POS_OUT_W-1:0]     rsp_best_row,
   output logic [POS_OUT_W-1:0]     rsp_best_col,
   output logic                     rsp_last_cell,
   input  logic                     csr_we,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   localparam int CPW = $clog2(MAX_COLS + 1);
   localparam int RPW = $clog2(MAX_ROWS + 1);
   localparam int VW  = (SCORE_BITS > CSR_W) ? SCORE_BITS : CSR_W;

   logic signed [CSR_W-1:0] row_gap_open_ff, row_gap_open_in;
   logic signed [CSR_W-1:0] row_gap_extend_ff, row_gap_extend_in;
   logic signed [CSR_W-1:0] col_gap_open_ff, col_gap_open_in;
   logic signed [CSR_W-1:0] col_gap_extend_ff, col_gap_extend_in;
   logic [CSR_W-1:0]        col_count_ff, col_count_in;
   logic [CSR_W-1:0]        row_count_ff, row_count_in;

   logic req_accept, s2_fire, out_free;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [MATCH_W-1:0] s2_match_ff;
   logic [CPW-1:0]            s2_col_ff;
   logic [RPW-1:0]            s2_row_ff;
   lafa_flags_type            s2_flags_ff;

   logic [CPW-1:0]               seq_col, seq_eff_cols;
   logic [RPW-1:0]               seq_row;
   lafa_flags_type               seq_flags;
   logic signed [VW-1:0]         up_score, up_gap;
   logic signed [SCORE_BITS-1:0] wr_score, wr_gap;

   // CSR writes
   always_comb begin
      row_gap_open_in   = row_gap_open_ff;
      row_gap_extend_in = row_gap_extend_ff;
      col_gap_open_in   = col_gap_open_ff;
      col_gap_extend_in = col_gap_extend_ff;
      col_count_in      = col_count_ff;
      row_count_in      = row_count_ff;
      if (csr_we) begin
         case (lafa_csr_index_type'(csr_index))
            CSR_ROW_GAP_OPEN:   row_gap_open_in   = csr_wdata;
            CSR_ROW_GAP_EXTEND: row_gap_extend_in = csr_wdata;
            CSR_COL_GAP_OPEN:   col_gap_open_in   = csr_wdata;
            CSR_COL_GAP_EXTEND: col_gap_extend_in = csr_wdata;
            CSR_COL_COUNT:      col_count_in      = csr_wdata;
            CSR_ROW_COUNT:      row_count_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_gap_open_ff   <= ROW_GAP_OPEN_RST;
         row_gap_extend_ff <= ROW_GAP_EXTEND_RST;
         col_gap_open_ff   <= COL_GAP_OPEN_RST;
         col_gap_extend_ff <= COL_GAP_EXTEND_RST;
         col_count_ff      <= COL_COUNT_RST;
         row_count_ff      <= ROW_COUNT_RST;
      end else begin
         row_gap_open_ff   <= row_gap_open_in;
         row_gap_extend_ff <= row_gap_extend_in;
         col_gap_open_ff   <= col_gap_open_in;
         col_gap_extend_ff <= col_gap_extend_in;
         col_count_ff      <= col_count_in;
         row_count_ff      <= row_count_in;
      end
   end

   // two stages: store read, then recurrence into the result register
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s2_fire    = s2_valid_ff && out_free;
   assign req_ready  = !s2_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (req_accept) begin
         s2_valid_in = 1'b1;
      end else if (s2_fire) begin
         s2_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s2_match_ff <= req_match_score;
         s2_col_ff   <= seq_col;
         s2_row_ff   <= seq_row;
         s2_flags_ff <= seq_flags;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   lafa_seq #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .advance   (req_accept),
      .col_count (col_count_ff),
      .row_count (row_count_ff),
      .col_pos   (seq_col),
      .row_pos   (seq_row),
      .eff_cols  (seq_eff_cols),
      .flags     (seq_flags)
   );

   lafa_store #(
      .MAX_COLS   (MAX_COLS),
      .SCORE_BITS (SCORE_BITS)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .rd_en        (req_accept),
      .rd_addr      (seq_col),
      .wr_en        (s2_fire),
      .wr_addr      (s2_col_ff),
      .wr_score     (wr_score),
      .wr_gap       (wr_gap),
      .restart      (s2_fire && s2_flags_ff.last),
      .eff_cols     (seq_eff_cols),
      .col_gap_open (col_gap_open_ff),
      .row_gap_open (row_gap_open_ff),
      .up_score     (up_score),
      .up_gap       (up_gap)
   );

   lafa_cell #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .SCORE_BITS (SCORE_BITS)
   ) u_cell (
      .clock          (clock),
      .reset          (reset),
      .fire           (s2_fire),
      .flags          (s2_flags_ff),
      .match_score    (s2_match_ff),
      .col_pos        (s2_col_ff),
      .row_pos        (s2_row_ff),
      .up_mem         (up_score),
      .upgap_mem      (up_gap),
      .row_gap_open   (row_gap_open_ff),
      .row_gap_extend (row_gap_extend_ff),
      .col_gap_open   (col_gap_open_ff),
      .col_gap_extend (col_gap_extend_ff),
      .wr_score       (wr_score),
      .wr_gap         (wr_gap),
      .rsp_trace_code (rsp_trace_code),
      .rsp_cell_score (rsp_cell_score),
      .rsp_best_score (rsp_best_score),
      .rsp_best_row   (rsp_best_row),
      .rsp_best_col   (rsp_best_col),
      .rsp_last_cell  (rsp_last_cell)
   );

   `LAFA_ASSERT_IMPLY(a_best_covers_cell, rsp_valid_ff, rsp_best_score >= rsp_cell_score, "best score below cell score")
   `LAFA_ASSERT_IMPLY(a_no_best_no_pos, rsp_valid_ff && rsp_best_score == '0, rsp_best_row == '0 && rsp_best_col == '0, "best position set without a best score")
   `LAFA_ASSERT_NEXT(a_restart_pos, req_accept && seq_flags.last, seq_col == CPW'(1) && seq_row == RPW'(1), "position not restarted after last cell")
   `LAFA_ASSERT_NEXT(a_last_delivered, s2_fire && s2_flags_ff.last, rsp_valid_ff && rsp_last_cell, "last cell flag lost on the way out")

endmodule
